>>> hdl/pid_pkg.sv
`default_nettype none

package pid_pkg;

  // Field formats
  localparam int SIG_W      = 16;               // Q4.12 signal
  localparam int COEF_W     = 32;               // Q2.30 coefficient
  localparam int STATE_W    = 40;               // accumulator, 28 fraction bits
  localparam int SIG_FRAC   = SIG_W - 4;
  localparam int COEF_FRAC  = COEF_W - 2;
  localparam int STATE_FRAC = STATE_W - 12;

  // Derived widths
  localparam int ERR_W      = SIG_W + 1;
  localparam int ESUM_W     = SIG_W + 2;
  localparam int SC_SHIFT   = SIG_FRAC + COEF_FRAC - STATE_FRAC;
  localparam int LIM_SHIFT  = STATE_FRAC - SIG_FRAC;
  localparam int P_FULL_W   = COEF_W + ERR_W;
  localparam int I_FULL_W   = COEF_W + ESUM_W;
  localparam int D_FULL_W   = COEF_W + ERR_W;
  localparam int P_W        = P_FULL_W - SC_SHIFT;
  localparam int I_TERM_W   = I_FULL_W - SC_SHIFT;
  localparam int D_TERM_W   = D_FULL_W - SC_SHIFT;
  localparam int ISUM_W     = STATE_W + 1;
  localparam int PD_FULL_W  = COEF_W + STATE_W;
  localparam int PD_W       = PD_FULL_W - COEF_FRAC;
  localparam int DSUM_W     = PD_W + 1;
  localparam int U_W        = STATE_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_POLE = 3'd2,
    CFG_DERIV_GAIN = 3'd3,
    CFG_OUT_MIN    = 3'd4,
    CFG_OUT_MAX    = 3'd5
  } pid_cfg_idx_t;

  localparam logic signed [COEF_W-1:0] PROP_GAIN_RST  = 32'sd1073741824;
  localparam logic signed [COEF_W-1:0] INTEG_GAIN_RST = 32'sd268435;
  localparam logic signed [COEF_W-1:0] DERIV_POLE_RST = 32'sd991146299;
  localparam logic signed [COEF_W-1:0] DERIV_GAIN_RST = 32'sd1651910498;
  localparam logic signed [SIG_W-1:0]  OUT_MIN_RST    = -16'sd4096;
  localparam logic signed [SIG_W-1:0]  OUT_MAX_RST    = 16'sd4096;

  typedef struct packed {
    logic signed [COEF_W-1:0] prop_gain;
    logic signed [COEF_W-1:0] integ_gain_half_period;
    logic signed [COEF_W-1:0] deriv_pole;
    logic signed [COEF_W-1:0] deriv_gain;
    logic signed [SIG_W-1:0]  out_min;
    logic signed [SIG_W-1:0]  out_max;
  } pid_cfg_t;

  // Differences formed at the input register
  typedef struct packed {
    logic                     mode;
    logic                     err_pos;
    logic                     err_neg;
    logic signed [ERR_W-1:0]  err;
    logic signed [ESUM_W-1:0] err_sum;
    logic signed [ERR_W-1:0]  meas_diff;
  } pid_diff_t;

  // Scaled products, state format
  typedef struct packed {
    logic                       mode;
    logic                       err_pos;
    logic                       err_neg;
    logic signed [P_W-1:0]      p_term;
    logic signed [I_TERM_W-1:0] i_term;
    logic signed [D_TERM_W-1:0] d_term;
  } pid_term_t;

endpackage

`default_nettype wire

>>> hdl/pid_stream_if.sv
`default_nettype none

interface pid_in_if import pid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SIG_W-1:0] setpoint;
  logic signed [SIG_W-1:0] measurement;
  logic                    mode;

  modport source(output valid, output setpoint, output measurement, output mode,
                 input ready);
  modport sink(input valid, input setpoint, input measurement, input mode,
               output ready);
endinterface

interface pid_out_if import pid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SIG_W-1:0] drive;
  logic                    saturated;

  modport source(output valid, output drive, output saturated, input ready);
  modport sink(input valid, input drive, input saturated, output ready);
endinterface

`default_nettype wire

>>> hdl/pid_cfg.sv
`default_nettype none

module pid_cfg import pid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output pid_cfg_t             cfg
);

  // Write one register per transfer; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain              <= PROP_GAIN_RST;
      cfg.integ_gain_half_period <= INTEG_GAIN_RST;
      cfg.deriv_pole             <= DERIV_POLE_RST;
      cfg.deriv_gain             <= DERIV_GAIN_RST;
      cfg.out_min                <= OUT_MIN_RST;
      cfg.out_max                <= OUT_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROP_GAIN:  cfg.prop_gain              <= cfg_wdata;
        CFG_INTEG_GAIN: cfg.integ_gain_half_period <= cfg_wdata;
        CFG_DERIV_POLE: cfg.deriv_pole             <= cfg_wdata;
        CFG_DERIV_GAIN: cfg.deriv_gain             <= cfg_wdata;
        CFG_OUT_MIN:    cfg.out_min                <= cfg_wdata[SIG_W-1:0];
        CFG_OUT_MAX:    cfg.out_max                <= cfg_wdata[SIG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/pid_front.sv
`default_nettype none

module pid_front import pid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pid_in_if.sink    sample,
  output logic      a_valid,
  input  logic      a_ready,
  output pid_diff_t a_data
);

  logic signed [ERR_W-1:0]  prev_error;
  logic signed [SIG_W-1:0]  prev_meas;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  meas_diff;
  logic signed [ESUM_W-1:0] err_sum;
  logic                     take;

  assign sample.ready = !a_valid || a_ready;
  assign take         = sample.valid && sample.ready;

  // Error, trapezoid sum and measurement step, all exact
  assign err       = $signed({sample.setpoint[SIG_W-1], sample.setpoint})
                   - $signed({sample.measurement[SIG_W-1], sample.measurement});
  assign meas_diff = $signed({sample.measurement[SIG_W-1], sample.measurement})
                   - $signed({prev_meas[SIG_W-1], prev_meas});
  assign err_sum   = $signed({err[ERR_W-1], err})
                   + $signed({prev_error[ERR_W-1], prev_error});

  // History updates on every transfer, in both modes
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      prev_error <= '0;
      prev_meas  <= '0;
    end else if (take) begin
      a_valid    <= 1'b1;
      prev_error <= err;
      prev_meas  <= sample.measurement;
    end else if (a_ready) begin
      a_valid    <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (take) begin
      a_data.mode      <= sample.mode;
      a_data.err_neg   <= err[ERR_W-1];
      a_data.err_pos   <= !err[ERR_W-1] && (err != '0);
      a_data.err       <= err;
      a_data.err_sum   <= err_sum;
      a_data.meas_diff <= meas_diff;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pid_mult.sv
`default_nettype none

module pid_mult import pid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pid_cfg_t  cfg,
  input  logic      a_valid,
  output logic      a_ready,
  input  pid_diff_t a_data,
  output logic      b_valid,
  input  logic      b_ready,
  output pid_term_t b_data
);

  logic signed [P_FULL_W-1:0] p_full;
  logic signed [I_FULL_W-1:0] i_full;
  logic signed [D_FULL_W-1:0] d_full;
  logic                       load;

  assign a_ready = !b_valid || b_ready;
  assign load    = a_valid && a_ready;

  // Three independent exact products
  assign p_full = $signed(cfg.prop_gain) * $signed(a_data.err);
  assign i_full = $signed(cfg.integ_gain_half_period) * $signed(a_data.err_sum);
  assign d_full = $signed(cfg.deriv_gain) * $signed(a_data.meas_diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (load) begin
      b_valid <= 1'b1;
    end else if (b_ready) begin
      b_valid <= 1'b0;
    end
  end

  // Scale to state format by dropping low bits (floor)
  always_ff @(posedge clk) begin
    if (load) begin
      b_data.mode    <= a_data.mode;
      b_data.err_pos <= a_data.err_pos;
      b_data.err_neg <= a_data.err_neg;
      b_data.p_term  <= p_full[P_FULL_W-1:SC_SHIFT];
      b_data.i_term  <= i_full[I_FULL_W-1:SC_SHIFT];
      b_data.d_term  <= d_full[D_FULL_W-1:SC_SHIFT];
    end
  end

endmodule

`default_nettype wire

>>> hdl/pid_core.sv
`default_nettype none

module pid_core import pid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pid_cfg_t  cfg,
  input  logic      b_valid,
  output logic      b_ready,
  input  pid_term_t b_data,
  pid_out_if.source result
);

  localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  logic signed [STATE_W-1:0]   integ_acc;
  logic signed [STATE_W-1:0]   deriv_acc;
  logic signed [STATE_W-1:0]   integ_next;
  logic signed [STATE_W-1:0]   deriv_next;
  logic signed [ISUM_W-1:0]    i_sum;
  logic signed [PD_FULL_W-1:0] pd_full;
  logic signed [PD_W-1:0]      pd;
  logic signed [DSUM_W-1:0]    d_sum;
  logic signed [STATE_W-1:0]   i_new;
  logic signed [STATE_W-1:0]   d_new;
  logic signed [U_W-1:0]       u;
  logic signed [U_W-1:0]       hi_lim;
  logic signed [U_W-1:0]       lo_lim;
  logic [ISUM_W-STATE_W:0]     i_top;
  logic [DSUM_W-STATE_W:0]     d_top;
  logic                        over_hi;
  logic                        under_lo;
  logic                        out_valid;
  logic signed [SIG_W-1:0]     drive;
  logic                        saturated;
  logic signed [SIG_W-1:0]     drive_next;
  logic                        sat_next;
  logic                        load;

  assign b_ready = !out_valid || result.ready;
  assign load    = b_valid && b_ready;

  // Integrator: add and saturate
  assign i_sum = $signed({integ_acc[STATE_W-1], integ_acc})
               + $signed({{(ISUM_W-I_TERM_W){b_data.i_term[I_TERM_W-1]}}, b_data.i_term});
  assign i_top = i_sum[ISUM_W-1:STATE_W-1];
  assign i_new = (!(&i_top) && (|i_top)) ? (i_sum[ISUM_W-1] ? STATE_MIN : STATE_MAX)
                                         : i_sum[STATE_W-1:0];

  // Derivative filter: feedback product, add input term, saturate
  assign pd_full = $signed(cfg.deriv_pole) * $signed(deriv_acc);
  assign pd      = pd_full[PD_FULL_W-1:COEF_FRAC];
  assign d_sum   = $signed({pd[PD_W-1], pd})
                 + $signed({{(DSUM_W-D_TERM_W){b_data.d_term[D_TERM_W-1]}}, b_data.d_term});
  assign d_top   = d_sum[DSUM_W-1:STATE_W-1];
  assign d_new   = (!(&d_top) && (|d_top)) ? (d_sum[DSUM_W-1] ? STATE_MIN : STATE_MAX)
                                           : d_sum[STATE_W-1:0];

  // Raw output P + I - D, exact
  assign u = $signed({{(U_W-P_W){b_data.p_term[P_W-1]}}, b_data.p_term})
           + $signed({{(U_W-STATE_W){i_new[STATE_W-1]}}, i_new})
           - $signed({{(U_W-STATE_W){d_new[STATE_W-1]}}, d_new});

  // Limits in state format
  assign hi_lim = {{(U_W-SIG_W-LIM_SHIFT){cfg.out_max[SIG_W-1]}}, cfg.out_max,
                   {LIM_SHIFT{1'b0}}};
  assign lo_lim = {{(U_W-SIG_W-LIM_SHIFT){cfg.out_min[SIG_W-1]}}, cfg.out_min,
                   {LIM_SHIFT{1'b0}}};
  assign over_hi  = u > hi_lim;
  assign under_lo = u < lo_lim;

  // Clamp, anti-windup and reinitialise
  always_comb begin
    drive_next = u[LIM_SHIFT+SIG_W-1:LIM_SHIFT];
    sat_next   = 1'b0;
    integ_next = i_new;
    deriv_next = d_new;
    if (b_data.mode) begin
      drive_next = '0;
      integ_next = '0;
      deriv_next = '0;
    end else if (over_hi) begin
      drive_next = cfg.out_max;
      sat_next   = 1'b1;
      if (b_data.err_pos) begin
        integ_next = integ_acc;
      end
    end else if (under_lo) begin
      drive_next = cfg.out_min;
      sat_next   = 1'b1;
      if (b_data.err_neg) begin
        integ_next = integ_acc;
      end
    end
  end

  // Accumulators and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      integ_acc <= '0;
      deriv_acc <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      integ_acc <= integ_next;
      deriv_acc <= deriv_next;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (load) begin
      drive     <= drive_next;
      saturated <= sat_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.drive     = drive;
  assign result.saturated = saturated;

endmodule

`default_nettype wire

>>> hdl/pid_controller_step.sv
// Channel   Dir  Payload                          Transfer
// sample    in   setpoint, measurement, mode      valid && ready
// result    out  drive, saturated                 valid && ready
// cfg       in   cfg_index, cfg_wdata             cfg_wr_en
//
// One item enters per cycle while the result is not stalled; it passes the input, product and result registers in turn.
// The rate is set by the derivative filter update (a 32x40 product, add and
// saturate) that closes on itself within the last stage.
// Reset loads the default coefficients and limits, clears history and
// accumulators and empties the pipeline.
// A stalled result holds its register; earlier stages keep taking items until full.
`default_nettype none

module pid_controller_step import pid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  pid_in_if.sink               sample,
  pid_out_if.source            result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  pid_cfg_t  cfg;
  logic      a_valid;
  logic      a_ready;
  pid_diff_t a_data;
  logic      b_valid;
  logic      b_ready;
  pid_term_t b_data;

  pid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pid_front u_front (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .a_valid (a_valid),
    .a_ready (a_ready),
    .a_data  (a_data)
  );

  pid_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .a_valid (a_valid),
    .a_ready (a_ready),
    .a_data  (a_data),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_data  (b_data)
  );

  pid_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_data  (b_data),
    .result  (result)
  );

endmodule

`default_nettype wire
